/* design/ps2_mouse_packet_cursor_assert.svh */
// Assertion macros shared by the mouse packet cursor RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define PS2MC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ps2mc same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define PS2MC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ps2mc next-cycle check failed");

`endif

/* design/ps2mc_pkg.sv */
// Shared types, constants and helpers for the mouse packet cursor.
// No dependencies; used by all ps2mc modules and the top level.
`timescale 1ns / 1ps

package ps2mc_pkg;

    localparam int COORD_W = 12;
    localparam int BYTE_W  = 8;
    localparam int BTN_W   = 3;
    localparam int CFG_IDX_W = 4;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_X  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_Y  = 4'd3;

    // Reset values
    localparam logic [COORD_W-1:0] X_LIMIT_RST = 12'd799;
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = 12'd599;
    localparam logic [COORD_W-1:0] HOME_X_RST  = 12'd400;
    localparam logic [COORD_W-1:0] HOME_Y_RST  = 12'd300;

    // Flag byte fields
    localparam logic [BYTE_W-1:0] SYNC_MASK = 8'h08;
    localparam logic [BYTE_W-1:0] OVF_MASK  = 8'hC0;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    typedef struct packed {
        logic [COORD_W-1:0] x_limit;
        logic [COORD_W-1:0] y_limit;
    } ps2mc_limits_t;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [BTN_W-1:0]   buttons;
        logic               packet_done;
        logic               overflow_drop;
        logic               moved;
    } ps2mc_result_t;

    // Clamp a signed coordinate sum to 0..limit.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [COORD_W+1:0] v,
        input logic [COORD_W-1:0]        limit
    );
        logic [COORD_W-1:0] r;
        if (v[COORD_W+1]) begin
            r = '0;
        end else if (v[COORD_W:0] > {1'b0, limit}) begin
            r = limit;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/ps2mc_cfg_regs.sv */
// Configuration register file for the mouse packet cursor.
// Depends on ps2mc_pkg.
`timescale 1ns / 1ps

module ps2mc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mc_pkg::COORD_W-1:0]    cfg_wdata,
    output ps2mc_pkg::ps2mc_limits_t         limits
);
    import ps2mc_pkg::*;

    logic [COORD_W-1:0] x_limit_reg, x_limit_next;
    logic [COORD_W-1:0] y_limit_reg, y_limit_next;

    // No home registers are kept here: the cursor resets to the home defaults, so
    // writes to the home indexes are accepted and have no further effect.
    always_comb begin
        x_limit_next = x_limit_reg;
        y_limit_next = y_limit_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_X_LIMIT: x_limit_next = cfg_wdata;
                REG_Y_LIMIT: y_limit_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end else begin
            x_limit_reg <= x_limit_next;
            y_limit_reg <= y_limit_next;
        end
    end

    assign limits.x_limit = x_limit_reg;
    assign limits.y_limit = y_limit_reg;

endmodule

/* design/ps2mc_decode.sv */
// Packet sync, delta build, cursor add/clamp and button state.
// Depends on ps2mc_pkg and ps2_mouse_packet_cursor_assert.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_cursor_assert.svh"

module ps2mc_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [ps2mc_pkg::BYTE_W-1:0]  rx_byte,
    input  ps2mc_pkg::ps2mc_limits_t      limits,
    output ps2mc_pkg::ps2mc_result_t      result
);
    import ps2mc_pkg::*;

    localparam logic [1:0] PH_SYNC   = 2'd0;
    localparam logic [1:0] PH_XDELTA = 2'd1;
    localparam logic [1:0] PH_YDELTA = 2'd2;

    logic [1:0]         phase_reg,  phase_next;
    logic [BYTE_W-1:0]  flag_reg,   flag_next;
    logic [BYTE_W-1:0]  xdelta_reg, xdelta_next;
    logic [COORD_W-1:0] pos_x_reg,  pos_x_next;
    logic [COORD_W-1:0] pos_y_reg,  pos_y_next;
    logic [BTN_W-1:0]   btn_reg,    btn_next;
    logic               done, drop, moved;

    logic signed [COORD_W+1:0] dx_ext, dy_ext, sum_x, sum_y;
    logic [COORD_W-1:0]        clamp_x, clamp_y;

    // 9-bit deltas, sign from the flag byte, widened to 14 bits
    assign dx_ext = {{(COORD_W+2-BYTE_W){flag_reg[XSIGN_BIT]}}, xdelta_reg};
    assign dy_ext = {{(COORD_W+2-BYTE_W){flag_reg[YSIGN_BIT]}}, rx_byte};
    assign sum_x  = $signed({2'b00, pos_x_reg}) + dx_ext;
    assign sum_y  = $signed({2'b00, pos_y_reg}) - dy_ext;  // screen y runs down
    assign clamp_x = clamp_coord(sum_x, limits.x_limit);
    assign clamp_y = clamp_coord(sum_y, limits.y_limit);

    always_comb begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        xdelta_next = xdelta_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        btn_next    = btn_reg;
        done        = 1'b0;
        drop        = 1'b0;
        moved       = 1'b0;
        case (phase_reg)
            PH_XDELTA: begin
                xdelta_next = rx_byte;
                phase_next  = PH_YDELTA;
            end
            PH_YDELTA: begin
                phase_next = PH_SYNC;
                if ((flag_reg & OVF_MASK) != '0) begin
                    drop = 1'b1;
                end else begin
                    pos_x_next = clamp_x;
                    pos_y_next = clamp_y;
                    btn_next   = flag_reg[BTN_W-1:0];
                    done       = 1'b1;
                    moved      = (clamp_x != pos_x_reg) || (clamp_y != pos_y_reg)
                                 || (flag_reg[BTN_W-1:0] != btn_reg);
                end
            end
            default: begin
                // waiting for sync; the unused phase code lands here too
                if ((rx_byte & SYNC_MASK) != '0) begin
                    flag_next  = rx_byte;
                    phase_next = PH_XDELTA;
                end else begin
                    phase_next = PH_SYNC;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC;
            flag_reg   <= '0;
            xdelta_reg <= '0;
            pos_x_reg  <= HOME_X_RST;
            pos_y_reg  <= HOME_Y_RST;
            btn_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            xdelta_reg <= xdelta_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            btn_reg    <= btn_next;
        end
    end

    assign result.cursor_x      = pos_x_next;
    assign result.cursor_y      = pos_y_next;
    assign result.buttons       = btn_next;
    assign result.packet_done   = done;
    assign result.overflow_drop = drop;
    assign result.moved         = moved;

    `PS2MC_ASSERT_NOW(a_clamp_x, aclk, aresetn, step && done, pos_x_next <= limits.x_limit)
    `PS2MC_ASSERT_NOW(a_clamp_y, aclk, aresetn, step && done, pos_y_next <= limits.y_limit)
    `PS2MC_ASSERT_NOW(a_done_xor_drop, aclk, aresetn, done || drop, done != drop)
    `PS2MC_ASSERT_NOW(a_moved_needs_done, aclk, aresetn, moved, done)
    `PS2MC_ASSERT_NEXT(a_done_resyncs, aclk, aresetn, step && (done || drop), phase_reg == PH_SYNC)

endmodule

/* design/ps2_mouse_packet_cursor.sv */
// Top level of the PS/2 three-byte mouse packet decoder with clamped cursor.
// Depends on ps2mc_pkg, ps2mc_cfg_regs and ps2mc_decode.
`timescale 1ns / 1ps

// Takes one received mouse byte per item and returns one result item per byte:
// the cursor position, the button bits and the packet status. Sync is found by
// skipping bytes with bit 3 clear while waiting for a flag byte; the next two
// bytes are the X and Y deltas. A packet with either overflow bit set is
// dropped (overflow_drop) and the decoder goes back to waiting for sync. An
// accepted packet adds X, subtracts Y (screen y grows downward), clamps both
// to 0..limit and loads the buttons (packet_done, plus moved if anything
// changed). The clamp only happens on an accepted packet, so a lowered limit
// takes effect at the next packet. The cursor starts at 400,300 after reset;
// home_x/home_y writes are accepted but only the reset value is ever used.
// Throughput is one byte per clock while m_ready holds high; a result is on
// the m_ side once its byte has passed the input register and then the result
// register, with the decode and add/clamp between them. While a result waits
// for m_ready the input register takes one more byte, then s_ready stays low
// until the result is taken.
// Config writes are always taken (cfg_ready is tied high) and should be made
// while idle.

module ps2_mouse_packet_cursor (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]      s_rx_byte,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ps2mc_pkg::COORD_W-1:0]     m_cursor_x,
    output logic [ps2mc_pkg::COORD_W-1:0]     m_cursor_y,
    output logic [ps2mc_pkg::BTN_W-1:0]       m_buttons,
    output logic                              m_packet_done,
    output logic                              m_overflow_drop,
    output logic                              m_moved,
    // config write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ps2mc_pkg::COORD_W-1:0]     cfg_wdata
);
    import ps2mc_pkg::*;

    logic               in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_vld_reg, out_vld_next;
    ps2mc_result_t      out_res_reg;
    ps2mc_result_t      dec_res;
    ps2mc_limits_t      limits;
    logic               advance;
    logic               s_take;

    assign cfg_ready = 1'b1;

    ps2mc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    // Byte in the input register moves into the decoder when the result
    // register is free or being emptied this cycle.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    ps2mc_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .limits  (limits),
        .result  (dec_res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_cursor_x      = out_res_reg.cursor_x;
    assign m_cursor_y      = out_res_reg.cursor_y;
    assign m_buttons       = out_res_reg.buttons;
    assign m_packet_done   = out_res_reg.packet_done;
    assign m_overflow_drop = out_res_reg.overflow_drop;
    assign m_moved         = out_res_reg.moved;

endmodule

/* test/tb_ps2_mouse_packet_cursor.sv */
// Self-checking testbench for ps2_mouse_packet_cursor: byte stream in, cursor reports out.
// Depends on ps2mc_pkg and the ps2_mouse_packet_cursor RTL; needs no other file.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor;
    import ps2mc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SHOWN_ERRORS = 10;

    // An index past the four defined register indexes; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

    // Packet assembly phases of the decoder.
    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } pkt_phase_t;

    // Clock, reset and DUT ports. Every signal the bench drives starts at a known value.
    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte       = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [COORD_W-1:0]   m_cursor_x;
    logic [COORD_W-1:0]   m_cursor_y;
    logic [BTN_W-1:0]     m_buttons;
    logic                 m_packet_done;
    logic                 m_overflow_drop;
    logic                 m_moved;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [COORD_W-1:0]   cfg_wdata       = '0;

    // Bytes still to be sent, and cursor reports still to be received.
    logic [BYTE_W-1:0]    rx_bytes_q[$];
    ps2mc_result_t        pending_reports[$];

    // Decoder mirror: packet phase, latched flag and x delta, cursor and buttons.
    pkt_phase_t           pkt_phase;
    logic [BYTE_W-1:0]    flag_q;
    logic [BYTE_W-1:0]    xdelta_q;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [BTN_W-1:0]     btn_q;

    // Limits as currently programmed. Home values only matter at reset.
    logic [COORD_W-1:0]   x_lim;
    logic [COORD_W-1:0]   y_lim;

    int                   err_cnt   = 0;
    int unsigned          cyc_cnt   = 0;
    int                   burst_left = 0;
    int                   gap_left   = 0;
    int                   stall_left = 0;
    int                   stall_mode = 0;
    ps2mc_result_t        want;

    ps2_mouse_packet_cursor u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_buttons       (m_buttons),
        .m_packet_done   (m_packet_done),
        .m_overflow_drop (m_overflow_drop),
        .m_moved         (m_moved),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the DUT hangs on either handshake.
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("tb_ps2_mouse_packet_cursor: FAIL");
            $finish;
        end
    end

    task automatic note_failure(input string what);
        err_cnt++;
        if (err_cnt <= SHOWN_ERRORS) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    function automatic logic [COORD_W-1:0] clamp_to(input int v, input logic [COORD_W-1:0] lim);
        if (v < 0) begin
            return '0;
        end
        if (v > int'(lim)) begin
            return lim;
        end
        return v[COORD_W-1:0];
    endfunction

    // Advance the decoder mirror by one received byte and return the report
    // the DUT should give for it. Every byte yields exactly one report.
    function automatic ps2mc_result_t decode_mouse_byte(input logic [BYTE_W-1:0] b);
        ps2mc_result_t      r;
        int                 vx;
        int                 vy;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        r = '0;
        case (pkt_phase)
            PH_XDELTA: begin
                xdelta_q  = b;
                pkt_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                pkt_phase = PH_SYNC;
                if ((flag_q & OVF_MASK) != '0) begin
                    // overflow: cursor and buttons untouched, back to hunting sync
                    r.overflow_drop = 1'b1;
                end else begin
                    // 9-bit deltas, sign in the flag byte; screen y grows downward
                    vx = int'(pos_x) + int'(xdelta_q) - (flag_q[XSIGN_BIT] ? 256 : 0);
                    vy = int'(pos_y) - (int'(b) - (flag_q[YSIGN_BIT] ? 256 : 0));
                    nx = clamp_to(vx, x_lim);
                    ny = clamp_to(vy, y_lim);
                    r.moved = (nx != pos_x) || (ny != pos_y) || (flag_q[BTN_W-1:0] != btn_q);
                    pos_x   = nx;
                    pos_y   = ny;
                    btn_q   = flag_q[BTN_W-1:0];
                    r.packet_done = 1'b1;
                end
            end
            default: begin
                // hunting sync (the unused fourth phase behaves the same)
                if ((b & SYNC_MASK) != '0) begin
                    flag_q    = b;
                    pkt_phase = PH_XDELTA;
                end else begin
                    pkt_phase = PH_SYNC;
                end
            end
        endcase
        r.cursor_x = pos_x;
        r.cursor_y = pos_y;
        r.buttons  = btn_q;
        return r;
    endfunction

    // Byte driver. Pulls from rx_bytes_q in bursts of random length with
    // random gaps, holds a byte steady until it is taken, and predicts the
    // report for every byte at the edge where it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_rx_byte  <= '0;
            pkt_phase  = PH_SYNC;
            flag_q     = '0;
            xdelta_q   = '0;
            pos_x      = HOME_X_RST;
            pos_y      = HOME_Y_RST;
            btn_q      = '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_reports.push_back(decode_mouse_byte(s_rx_byte));
            end
            if (s_valid && !s_ready) begin
                // not taken yet: byte and valid stay as they are
            end else if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (rx_bytes_q.size() != 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= rx_bytes_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Report monitor. Checks each accepted report against the oldest
    // prediction, and stalls m_ready in randomly chosen modes: always ready,
    // coin flip, periodic stall, long stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            stall_mode <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    note_failure($sformatf("report with nothing expected: x=%0d y=%0d",
                                           m_cursor_x, m_cursor_y));
                end else begin
                    want = pending_reports.pop_front();
                    if (m_cursor_x !== want.cursor_x || m_cursor_y !== want.cursor_y ||
                        m_buttons !== want.buttons || m_packet_done !== want.packet_done ||
                        m_overflow_drop !== want.overflow_drop || m_moved !== want.moved) begin
                        note_failure({
                            $sformatf("exp x=%0d y=%0d btn=%0d done=%0b drop=%0b mv=%0b",
                                      want.cursor_x, want.cursor_y, want.buttons,
                                      want.packet_done, want.overflow_drop, want.moved),
                            $sformatf(", got x=%0d y=%0d btn=%0d done=%0b drop=%0b mv=%0b",
                                      m_cursor_x, m_cursor_y, m_buttons,
                                      m_packet_done, m_overflow_drop, m_moved)});
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(16, 64);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (cyc_cnt % 5) != 0;
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // One register write; the limit mirror follows the write. Ends on a
    // falling edge so the caller can touch the queues without racing the driver.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_X_LIMIT: x_lim = val;
            REG_Y_LIMIT: y_lim = val;
            default: ;  // home values only load at reset; spare indexes are dropped
        endcase
        @(negedge aclk);
    endtask

    // Waits until every byte is sent and every report is back, then lets the
    // two-stage pipe settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (rx_bytes_q.size() != 0 || s_valid || pending_reports.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_packet(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] dx,
                               input logic [BYTE_W-1:0] dy);
        rx_bytes_q.push_back(flag);
        rx_bytes_q.push_back(dx);
        rx_bytes_q.push_back(dy);
    endtask

    // Mostly well-formed packets with random content. drift_pct of them push
    // the cursor hard in a slowly changing direction so the clamps get hit;
    // about one in eight keeps random overflow bits; one in ten slots is stray
    // bytes that can knock the stream out of packet alignment.
    task automatic queue_traffic(input int n_items, input int drift_pct);
        int                left;
        logic              dir_x;
        logic              dir_y;
        logic [BYTE_W-1:0] flag;
        left  = n_items;
        dir_x = 1'($urandom_range(0, 1));
        dir_y = 1'($urandom_range(0, 1));
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 2)) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                flag = 8'($urandom_range(0, 255)) | SYNC_MASK;
                if ($urandom_range(0, 7) != 0) begin
                    flag = flag & ~OVF_MASK;
                end
                if ($urandom_range(0, 15) == 0) dir_x = ~dir_x;
                if ($urandom_range(0, 15) == 0) dir_y = ~dir_y;
                if ($urandom_range(1, 100) <= drift_pct) begin
                    flag[XSIGN_BIT] = dir_x;
                    flag[YSIGN_BIT] = dir_y;
                    push_packet(flag,
                                dir_x ? 8'($urandom_range(0, 80)) : 8'($urandom_range(176, 255)),
                                dir_y ? 8'($urandom_range(0, 80)) : 8'($urandom_range(176, 255)));
                end else begin
                    push_packet(flag, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                left -= 3;
            end
        end
    endtask

    initial begin
        x_lim = X_LIMIT_RST;
        y_lim = Y_LIMIT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: cursor starts at 400,300 with the reset limits.
        rx_bytes_q.push_back(8'h00);         // sync bit clear: skipped
        rx_bytes_q.push_back(8'hF7);         // everything but sync set: skipped
        push_packet(8'h08, 8'h00, 8'h00);    // zero motion, no buttons: done, not moved
        push_packet(8'h0F, 8'hFF, 8'h80);    // max +x, +y, all buttons
        push_packet(8'h3A, 8'h00, 8'h00);    // both deltas at -256
        push_packet(8'h48, 8'h12, 8'h34);    // x overflow: dropped
        push_packet(8'hFF, 8'hFF, 8'hFF);    // both overflows, all ones: dropped
        push_packet(8'h18, 8'h00, 8'h7F);    // x at -256, y positive
        push_packet(8'h28, 8'h7F, 8'h01);    // y sign set with small byte: -255
        wait_idle();

        // Reset limits; the sender drains once in the middle of the phase.
        queue_traffic(45, 40);
        wait_idle();
        queue_traffic(45, 40);
        wait_idle();

        // Limits dropped to zero: the cursor is reported above them until
        // the next accepted packet clamps it.
        write_reg(REG_X_LIMIT, 12'd0);
        write_reg(REG_Y_LIMIT, 12'd0);
        rx_bytes_q.push_back(8'h00);
        push_packet(8'h08, 8'h00, 8'h00);
        queue_traffic(60, 30);
        wait_idle();

        // Widest limits. Home writes must not move the cursor, and a write to
        // a spare index must not touch any limit.
        write_reg(REG_X_LIMIT, 12'd4095);
        write_reg(REG_Y_LIMIT, 12'd4095);
        write_reg(REG_HOME_X, 12'd0);
        write_reg(REG_HOME_Y, 12'd4095);
        write_reg(REG_SPARE, 12'h123);
        queue_traffic(120, 70);
        wait_idle();

        // Random limits, home values at the other extremes.
        write_reg(REG_X_LIMIT, 12'($urandom_range(0, 4095)));
        write_reg(REG_Y_LIMIT, 12'($urandom_range(0, 4095)));
        write_reg(REG_HOME_X, 12'd4095);
        write_reg(REG_HOME_Y, 12'd0);
        queue_traffic(90, 50);
        wait_idle();

        // Small limits: clamps on almost every packet.
        write_reg(REG_X_LIMIT, 12'($urandom_range(1, 40)));
        write_reg(REG_Y_LIMIT, 12'($urandom_range(1, 40)));
        queue_traffic(90, 30);
        wait_idle();

        // Tail: catch any stray report after the last expected one.
        repeat (20) @(negedge aclk);
        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
        end
        if (err_cnt == 0) begin
            $display("tb_ps2_mouse_packet_cursor: PASS");
        end else begin
            $display("tb_ps2_mouse_packet_cursor: FAIL");
        end
        $finish;
    end

endmodule
